// ===== sv/mcd_pkg.sv =====
// types and constants shared by the directory engine
package mcd_pkg;
  localparam int NAME_W = 160;
  localparam int SIZE_W = 17;

  typedef enum logic [2:0] {
    FN_FORMAT   = 3'd0,
    FN_UNFORMAT = 3'd1,
    FN_CREATE   = 3'd2,
    FN_DELETE   = 3'd3,
    FN_SPAN     = 3'd4,
    FN_LIST     = 3'd5
  } func_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NOFMT   = 3'd1,
    ST_NOFILE  = 3'd2,
    ST_EXISTS  = 3'd3,
    ST_FULL    = 3'd4
  } status_t;

  localparam logic [7:0] ES_FIRST = 8'h51;
  localparam logic [7:0] ES_MID   = 8'h52;
  localparam logic [7:0] ES_LAST  = 8'h53;
  localparam logic [7:0] ES_FREE  = 8'hA0;
  localparam logic [3:0] LINK_END = 4'hF;

  typedef enum logic [3:0] {
    S_IDLE, S_FMT, S_FIND, S_FREE, S_BUILD, S_DEL, S_SPAN, S_LIST, S_OUT, S_FIN
  } fsm_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  block;
    logic [12:0] start_byte;
    logic [13:0] span_bytes;
    logic [16:0] file_size;
    logic [63:0] name0;
    logic [63:0] name1;
    logic [31:0] name2;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [7:0]        st;
    logic [3:0]        link;
    logic [SIZE_W-1:0] size;
    logic [NAME_W-1:0] name;
  } entry_t;
endpackage

// ===== sv/mcd_if.sv =====
// valid/ready channel interfaces
interface mcd_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [63:0] name_part0;
  logic [63:0] name_part1;
  logic [31:0] name_part2;
  logic [3:0]  block_count;
  logic [16:0] byte_offset;
  logic [16:0] byte_length;
  logic [3:0]  max_entries;
  modport source (output valid, func, name_part0, name_part1, name_part2, block_count,
    byte_offset, byte_length, max_entries, input ready);
  modport sink (input valid, func, name_part0, name_part1, name_part2, block_count,
    byte_offset, byte_length, max_entries, output ready);
endinterface

interface mcd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [3:0]  block;
  logic [12:0] start_byte;
  logic [13:0] span_bytes;
  logic [16:0] file_size;
  logic [63:0] out_name0;
  logic [63:0] out_name1;
  logic [31:0] out_name2;
  logic        last;
  modport source (output valid, status, block, start_byte, span_bytes, file_size,
    out_name0, out_name1, out_name2, last, input ready);
  modport sink (input valid, status, block, start_byte, span_bytes, file_size,
    out_name0, out_name1, out_name2, last, output ready);
endinterface

// ===== sv/mcd_dir_ram.sv =====
// directory memory, one entry per data block, registered read
module mcd_dir_ram
  import mcd_pkg::*;
#(
  parameter int DEPTH = 15,
  parameter int AW = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  entry_t        wdata,
  input  logic [AW-1:0] raddr,
  output entry_t        rdata
);
  entry_t mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== sv/memory_card_directory_engine_core.sv =====
// directory engine top level: sequencer over the directory memory
//  channel | dir | handshake    | payload
//  in_*    | in  | valid/ready  | func, name, count, offset, length, max
//  out_*   | out | valid/ready  | status, block, span, size, name, last
// one operation at a time; each memory pass reads the entries one at a time
// through the registered read, each read checked before the next is issued;
// create takes up to three passes (find, free count, build).
// after reset the sequencer clears the directory and takes no input meanwhile.
// a stalled result holds the sequencer at its current entry; input is taken
// only in idle once the last beat of the previous operation has left.
module memory_card_directory_engine_core
  import mcd_pkg::*;
#(
  parameter int DATA_BLOCKS = 15,
  parameter int BLOCK_BYTES = 8192
) (
  input  logic clk,
  input  logic rst_n,
  mcd_in_if.sink    in_ch,
  mcd_out_if.source out_ch
);
  localparam int AW = 4;
  localparam logic [17:0] BB = 18'(BLOCK_BYTES);
  localparam logic [AW-1:0] LASTI = AW'(DATA_BLOCKS - 1);

  fsm_t st_r, st_nxt, ret_r, ret_nxt;
  logic          fmt_r, fmt_nxt;
  logic [2:0]    func_r, func_nxt;
  logic [NAME_W-1:0] nm_r, nm_nxt;
  logic [3:0]    cnt_r, cnt_nxt, maxe_r, maxe_nxt;
  logic [17:0]   ofs_r, ofs_nxt, len_r, len_nxt, pos_r, pos_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic          rd_r, rd_nxt;
  logic [4:0]    hops_r, hops_nxt, got_r, got_nxt;
  logic [3:0]    k_r, k_nxt, head_r, head_nxt, prev_r, prev_nxt;
  logic          found_r, found_nxt;
  res_t          res_r, res_nxt;
  res_t          pend_r, pend_nxt;
  logic          ov_r, ov_nxt;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  entry_t        wdata, rdata;

  mcd_dir_ram #(.DEPTH(DATA_BLOCKS), .AW(AW)) u_ram (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  logic [17:0] start_c, n_c;
  logic [3:0]  nx_c;
  always_comb begin
    start_c = (ofs_r > pos_r) ? ofs_r - pos_r : 18'd0;
    n_c = BB - start_c;
    if (n_c > len_r) n_c = len_r;
    nx_c = (rdata.link >= 4'(DATA_BLOCKS)) ? 4'd0 : rdata.link + 4'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_FMT;  ret_r <= S_IDLE; fmt_r <= 1'b0; ov_r <= 1'b0;
      idx_r <= '0;    rd_r <= 1'b0;    func_r <= 3'd7;
    end else begin
      st_r <= st_nxt; ret_r <= ret_nxt; fmt_r <= fmt_nxt; ov_r <= ov_nxt;
      idx_r <= idx_nxt; rd_r <= rd_nxt; func_r <= func_nxt;
    end
    nm_r <= nm_nxt; cnt_r <= cnt_nxt; maxe_r <= maxe_nxt; ofs_r <= ofs_nxt;
    len_r <= len_nxt; pos_r <= pos_nxt; hops_r <= hops_nxt; got_r <= got_nxt;
    k_r <= k_nxt; head_r <= head_nxt; prev_r <= prev_nxt; found_r <= found_nxt;
    res_r <= res_nxt; pend_r <= pend_nxt;
  end

  assign in_ch.ready = (st_r == S_IDLE) && !ov_r;
  assign out_ch.valid = ov_r;
  assign out_ch.status = res_r.status;
  assign out_ch.block = res_r.block;
  assign out_ch.start_byte = res_r.start_byte;
  assign out_ch.span_bytes = res_r.span_bytes;
  assign out_ch.file_size = res_r.file_size;
  assign out_ch.out_name0 = res_r.name0;
  assign out_ch.out_name1 = res_r.name1;
  assign out_ch.out_name2 = res_r.name2;
  assign out_ch.last = res_r.last;

  always_comb begin
    st_nxt = st_r; ret_nxt = ret_r; fmt_nxt = fmt_r; func_nxt = func_r;
    nm_nxt = nm_r; cnt_nxt = cnt_r; maxe_nxt = maxe_r; ofs_nxt = ofs_r;
    len_nxt = len_r; pos_nxt = pos_r; idx_nxt = idx_r; rd_nxt = rd_r;
    hops_nxt = hops_r; got_nxt = got_r; k_nxt = k_r; head_nxt = head_r;
    prev_nxt = prev_r; found_nxt = found_r; res_nxt = res_r; pend_nxt = pend_r;
    ov_nxt = ov_r && !out_ch.ready;
    we = 1'b0; waddr = idx_r; raddr = idx_r;
    wdata = '{st: ES_FREE, link: LINK_END, size: '0, name: '0};
    unique case (st_r)
      S_IDLE: begin
        if (in_ch.valid && !ov_r) begin
          func_nxt = in_ch.func;
          nm_nxt = {in_ch.name_part2, in_ch.name_part1, in_ch.name_part0};
          cnt_nxt = in_ch.block_count; maxe_nxt = in_ch.max_entries;
          ofs_nxt = {1'b0, in_ch.byte_offset}; len_nxt = {1'b0, in_ch.byte_length};
          pos_nxt = '0; idx_nxt = '0; rd_nxt = 1'b0; hops_nxt = '0; k_nxt = '0;
          found_nxt = 1'b0; got_nxt = '0; prev_nxt = LINK_END;
          res_nxt = '0; res_nxt.last = 1'b1;
          unique case (in_ch.func)
            FN_FORMAT: begin
              fmt_nxt = 1'b1; st_nxt = S_FMT; ret_nxt = S_OUT;
            end
            FN_UNFORMAT: begin
              fmt_nxt = 1'b0; st_nxt = S_OUT;
            end
            FN_CREATE: begin
              if (!fmt_r) begin
                res_nxt.status = ST_NOFMT; st_nxt = S_OUT;
              end else if (in_ch.block_count == 4'd0) begin
                res_nxt.status = ST_NOFILE; st_nxt = S_OUT;
              end else st_nxt = S_FIND;
            end
            FN_DELETE, FN_SPAN: st_nxt = S_FIND;
            FN_LIST: st_nxt = S_LIST;
            default: st_nxt = S_IDLE;
          endcase
        end
      end
      S_FMT: begin
        we = 1'b1;
        idx_nxt = idx_r + 1'b1;
        if (idx_r == LASTI) begin
          idx_nxt = '0; st_nxt = (ret_r == S_OUT) ? S_OUT : S_IDLE;
        end
      end
      S_FIND: begin
        // issue read, then check on next cycle
        if (!rd_r) rd_nxt = 1'b1;
        else begin
          rd_nxt = 1'b0;
          if (rdata.st == ES_FIRST && rdata.name == nm_r) begin
            found_nxt = 1'b1; head_nxt = 4'(idx_r) + 4'd1;
            st_nxt = (func_r == FN_CREATE) ? S_OUT : S_FREE;
            if (func_r == FN_CREATE) res_nxt.status = ST_EXISTS;
            else begin
              st_nxt = (func_r == FN_DELETE) ? S_DEL : S_SPAN;
              idx_nxt = idx_r;
            end
          end else if (idx_r == LASTI) begin
            idx_nxt = '0;
            if (func_r == FN_CREATE) st_nxt = S_FREE;
            else begin
              res_nxt.status = ST_NOFILE; st_nxt = S_OUT;
            end
          end else idx_nxt = idx_r + 1'b1;
        end
      end
      S_FREE: begin
        // count free blocks
        if (!rd_r) rd_nxt = 1'b1;
        else begin
          rd_nxt = 1'b0;
          if (rdata.st[7:4] != 4'h5) got_nxt = got_r + 5'd1;
          if (idx_r == LASTI) begin
            idx_nxt = '0;
            if ({1'b0, cnt_r} > ((rdata.st[7:4] != 4'h5) ? got_r + 5'd1 : got_r)) begin
              res_nxt.status = ST_FULL; st_nxt = S_OUT;
            end else begin
              st_nxt = S_BUILD; got_nxt = '0;
            end
          end else idx_nxt = idx_r + 1'b1;
        end
      end
      S_BUILD: begin
        // write each chosen block once the next one is known
        if (!rd_r) rd_nxt = 1'b1;
        else begin
          rd_nxt = 1'b0;
          idx_nxt = idx_r + 1'b1;
          if (rdata.st[7:4] != 4'h5) begin
            got_nxt = got_r + 5'd1;
            if (got_r != 5'd0) begin
              we = 1'b1; waddr = AW'(prev_r);
              wdata.st = (got_r == 5'd1) ? ES_FIRST : ES_MID;
              wdata.link = 4'(idx_r);
              wdata.size = (got_r == 5'd1) ? SIZE_W'(cnt_r * BB) : '0;
              wdata.name = (got_r == 5'd1) ? nm_r : '0;
            end
            prev_nxt = 4'(idx_r);
            if (got_r + 5'd1 == {1'b0, cnt_r}) begin
              st_nxt = S_FIN;
            end
          end
        end
      end
      S_FIN: begin
        we = 1'b1; waddr = AW'(prev_r);
        wdata.st = (cnt_r == 4'd1) ? ES_FIRST : ES_LAST;
        wdata.link = LINK_END;
        wdata.size = (cnt_r == 4'd1) ? SIZE_W'(cnt_r * BB) : '0;
        wdata.name = (cnt_r == 4'd1) ? nm_r : '0;
        st_nxt = S_OUT;
      end
      S_DEL: begin
        raddr = AW'(head_r - 4'd1);
        if (!rd_r) rd_nxt = 1'b1;
        else begin
          rd_nxt = 1'b0;
          we = 1'b1; waddr = AW'(head_r - 4'd1);
          wdata = rdata; wdata.st = {4'hA, rdata.st[3:0]};
          hops_nxt = hops_r + 5'd1;
          head_nxt = nx_c;
          if (nx_c == 4'd0 || hops_r + 5'd1 == 5'(DATA_BLOCKS)) st_nxt = S_OUT;
        end
      end
      S_SPAN: begin
        raddr = AW'(head_r - 4'd1);
        if (head_r == 4'd0 || len_r == '0 || hops_r == 5'(DATA_BLOCKS)) begin
          if (!ov_r || out_ch.ready) begin
            if (len_r != '0 && k_r != 4'd0) begin
              // held part goes out ahead of the failure beat
              ov_nxt = 1'b1; res_nxt = pend_r; k_nxt = 4'd0;
            end else begin
              res_nxt = '0;
              if (len_r != '0) res_nxt.status = ST_NOFILE;
              else if (k_r != 4'd0) res_nxt = pend_r;
              res_nxt.last = 1'b1;
              st_nxt = S_OUT;
            end
          end
        end else if (!rd_r) rd_nxt = 1'b1;
        else if (ofs_r < pos_r + BB) begin
          // hold the computed part until the next one decides last
          if (k_r == 4'd0 || !ov_r || out_ch.ready) begin
            if (k_r != 4'd0) begin
              ov_nxt = 1'b1; res_nxt = pend_r;
            end
            pend_nxt = '0;
            pend_nxt.block = head_r;
            pend_nxt.start_byte = start_c[12:0];
            pend_nxt.span_bytes = n_c[13:0];
            k_nxt = k_r + 4'd1;
            ofs_nxt = ofs_r + n_c; len_nxt = len_r - n_c;
            pos_nxt = pos_r + BB; head_nxt = nx_c; hops_nxt = hops_r + 5'd1;
            rd_nxt = 1'b0;
          end
        end else begin
          pos_nxt = pos_r + BB; head_nxt = nx_c; hops_nxt = hops_r + 5'd1;
          rd_nxt = 1'b0;
        end
      end
      S_LIST: begin
        if (!rd_r) rd_nxt = 1'b1;
        else if (k_r == maxe_r || (rdata.st != ES_FIRST)) begin
          rd_nxt = 1'b0;
          if (k_r == maxe_r || idx_r == LASTI) begin
            if (!ov_r || out_ch.ready) begin
              res_nxt = '0;
              if (k_r != 4'd0) res_nxt = pend_r;
              res_nxt.last = 1'b1; st_nxt = S_OUT;
            end else rd_nxt = 1'b1;
          end else idx_nxt = idx_r + 1'b1;
        end else if (k_r == 4'd0 || !ov_r || out_ch.ready) begin
          if (k_r != 4'd0) begin
            ov_nxt = 1'b1; res_nxt = pend_r;
          end
          pend_nxt = '0;
          pend_nxt.block = 4'(idx_r) + 4'd1;
          pend_nxt.file_size = rdata.size;
          {pend_nxt.name2, pend_nxt.name1, pend_nxt.name0} = rdata.name;
          k_nxt = k_r + 4'd1; rd_nxt = 1'b0;
          // last entry: close the scan through the entry limit
          if (idx_r == LASTI) maxe_nxt = k_r + 4'd1;
          else idx_nxt = idx_r + 1'b1;
        end
      end
      S_OUT: begin
        if (!ov_r || out_ch.ready) begin
          ov_nxt = 1'b1; st_nxt = S_IDLE; idx_nxt = '0;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end
endmodule

// ===== tb/memory_card_directory_engine_core_tb.sv =====
// self-checking testbench for the memory card directory engine core
module memory_card_directory_engine_core_tb
  import mcd_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NBLK = 15;
  localparam int BBYTES = 8192;
  localparam int SETTLE = 200;

  logic clk;
  logic rst_n;

  mcd_in_if in_ch ();
  mcd_out_if out_ch ();

  memory_card_directory_engine_core #(
    .DATA_BLOCKS(NBLK),
    .BLOCK_BYTES(BBYTES)
  ) u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // directory mirror
  logic          card_fmt;
  logic [7:0]    dir_st [NBLK];
  logic [3:0]    dir_link [NBLK];
  logic [16:0]   dir_size [NBLK];
  logic [63:0]   dir_na [NBLK];
  logic [63:0]   dir_nb [NBLK];
  logic [31:0]   dir_nc [NBLK];

  res_t expected_beats [$];
  int   errors = 0;
  int   items_sent = 0;
  int   beats_seen = 0;
  int   stall_mode = 0;

  logic [63:0] pool_a [6];
  logic [63:0] pool_b [6];
  logic [31:0] pool_c [6];

  function automatic res_t mk(logic [2:0] st, logic [3:0] blk, logic [12:0] sb,
                              logic [13:0] sp, logic [16:0] fs, logic [63:0] n0,
                              logic [63:0] n1, logic [31:0] n2, logic lst);
    res_t r;
    r.status = st;
    r.block = blk;
    r.start_byte = sb;
    r.span_bytes = sp;
    r.file_size = fs;
    r.name0 = n0;
    r.name1 = n1;
    r.name2 = n2;
    r.last = lst;
    return r;
  endfunction

  function automatic int head_of(logic [63:0] a, logic [63:0] b, logic [31:0] c);
    for (int i = 0; i < NBLK; i++)
      if (dir_st[i] == ES_FIRST && dir_na[i] == a && dir_nb[i] == b && dir_nc[i] == c)
        return i + 1;
    return 0;
  endfunction

  function automatic int next_blk(int b);
    if (dir_link[b-1] >= NBLK) return 0;
    return int'(dir_link[b-1]) + 1;
  endfunction

  task automatic predict_op(logic [2:0] fn, logic [63:0] na, logic [63:0] nb,
                            logic [31:0] nc, logic [3:0] cnt, logic [16:0] ofs_in,
                            logic [16:0] len_in, logic [3:0] maxe);
    int chain [NBLK];
    int got;
    int b;
    int nx;
    int hops;
    int k;
    int unsigned pos;
    int unsigned ofs;
    int unsigned len;
    int unsigned start;
    int unsigned n;
    bit fail;
    logic [2:0] st;
    got = 0;
    k = 0;
    fail = 0;
    case (fn)
      FN_FORMAT: begin
        card_fmt = 1'b1;
        for (int i = 0; i < NBLK; i++) begin
          dir_st[i] = ES_FREE;
          dir_link[i] = LINK_END;
          dir_size[i] = '0;
          dir_na[i] = '0;
          dir_nb[i] = '0;
          dir_nc[i] = '0;
        end
        expected_beats.push_back(mk(ST_OK, 0, 0, 0, 0, 0, 0, 0, 1));
      end
      FN_UNFORMAT: begin
        card_fmt = 1'b0;
        expected_beats.push_back(mk(ST_OK, 0, 0, 0, 0, 0, 0, 0, 1));
      end
      FN_CREATE: begin
        if (!card_fmt) st = ST_NOFMT;
        else if (cnt == 0) st = ST_NOFILE;
        else if (head_of(na, nb, nc) != 0) st = ST_EXISTS;
        else begin
          for (int i = 0; i < NBLK && got < cnt; i++)
            if ((dir_st[i] & 8'hF0) != 8'h50) begin
              chain[got] = i;
              got++;
            end
          if (got < cnt) st = ST_FULL;
          else begin
            st = ST_OK;
            for (int i = 0; i < cnt; i++) begin
              dir_st[chain[i]] = (i == 0) ? ES_FIRST : ((i == cnt - 1) ? ES_LAST : ES_MID);
              dir_link[chain[i]] = (i == cnt - 1) ? LINK_END : 4'(chain[i+1]);
              if (i == 0) begin
                dir_size[chain[i]] = 17'(cnt * BBYTES);
                dir_na[chain[i]] = na;
                dir_nb[chain[i]] = nb;
                dir_nc[chain[i]] = nc;
              end else begin
                dir_size[chain[i]] = '0;
                dir_na[chain[i]] = '0;
                dir_nb[chain[i]] = '0;
                dir_nc[chain[i]] = '0;
              end
            end
          end
        end
        expected_beats.push_back(mk(st, 0, 0, 0, 0, 0, 0, 0, 1));
      end
      FN_DELETE: begin
        b = head_of(na, nb, nc);
        if (b == 0) expected_beats.push_back(mk(ST_NOFILE, 0, 0, 0, 0, 0, 0, 0, 1));
        else begin
          for (hops = 0; b != 0 && hops < NBLK; hops++) begin
            nx = next_blk(b);
            dir_st[b-1] = (dir_st[b-1] & 8'h0F) | 8'hA0;
            b = nx;
          end
          expected_beats.push_back(mk(ST_OK, 0, 0, 0, 0, 0, 0, 0, 1));
        end
      end
      FN_SPAN: begin
        b = head_of(na, nb, nc);
        ofs = ofs_in;
        len = len_in;
        pos = 0;
        hops = 0;
        if (b == 0) expected_beats.push_back(mk(ST_NOFILE, 0, 0, 0, 0, 0, 0, 0, 1));
        else begin
          while (b != 0 && len > 0) begin
            if (hops >= NBLK) begin
              fail = 1;
              break;
            end
            hops++;
            if (ofs < pos + BBYTES) begin
              start = (ofs > pos) ? ofs - pos : 0;
              n = BBYTES - start;
              if (n > len) n = len;
              expected_beats.push_back(mk(ST_OK, 4'(b), 13'(start), 14'(n), 0, 0, 0, 0, 0));
              k++;
              ofs += n;
              len -= n;
            end
            pos += BBYTES;
            b = next_blk(b);
          end
          if (len > 0) fail = 1;
          if (fail || k == 0)
            expected_beats.push_back(mk(fail ? ST_NOFILE : ST_OK, 0, 0, 0, 0, 0, 0, 0, 1));
          else
            expected_beats[$].last = 1'b1;
        end
      end
      FN_LIST: begin
        for (int i = 0; i < NBLK && k < maxe; i++) begin
          if (dir_st[i] != ES_FIRST) continue;
          expected_beats.push_back(mk(ST_OK, 4'(i + 1), 0, 0, dir_size[i], dir_na[i],
                                      dir_nb[i], dir_nc[i], 0));
          k++;
        end
        if (k == 0) expected_beats.push_back(mk(ST_OK, 0, 0, 0, 0, 0, 0, 0, 1));
        else expected_beats[$].last = 1'b1;
      end
      default: ;
    endcase
  endtask

  task automatic send_op(logic [2:0] fn, logic [63:0] na, logic [63:0] nb,
                         logic [31:0] nc, logic [3:0] cnt, logic [16:0] ofs,
                         logic [16:0] len, logic [3:0] maxe);
    int gap;
    @(negedge clk);
    in_ch.valid = 1'b1;
    in_ch.func = fn;
    in_ch.name_part0 = na;
    in_ch.name_part1 = nb;
    in_ch.name_part2 = nc;
    in_ch.block_count = cnt;
    in_ch.byte_offset = ofs;
    in_ch.byte_length = len;
    in_ch.max_entries = maxe;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_op(fn, na, nb, nc, cnt, ofs, len, maxe);
    items_sent++;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 3);
    if (stall_mode == 0) gap = 0;
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic drain_all();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic send_named(logic [2:0] fn, int p, logic [3:0] cnt, logic [16:0] ofs,
                            logic [16:0] len, logic [3:0] maxe);
    send_op(fn, pool_a[p], pool_b[p], pool_c[p], cnt, ofs, len, maxe);
  endtask

  // output ready with random stalls
  always @(negedge clk) begin
    if (stall_mode == 0 || $urandom_range(0, 3) != 0) out_ch.ready <= 1'b1;
    else if ($urandom_range(0, 15) == 0) begin
      out_ch.ready <= 1'b0;
      repeat ($urandom_range(10, 50)) @(negedge clk);
    end else out_ch.ready <= 1'b0;
  end

  task automatic chk(string fld, logic [63:0] e, logic [63:0] a);
    if (e !== a) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, fld, e, a);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    res_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      beats_seen++;
      if (expected_beats.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual status %0d block %0d",
                 $time, out_ch.status, out_ch.block);
        errors++;
      end else begin
        e = expected_beats.pop_front();
        chk("status", e.status, out_ch.status);
        chk("block", e.block, out_ch.block);
        chk("start_byte", e.start_byte, out_ch.start_byte);
        chk("span_bytes", e.span_bytes, out_ch.span_bytes);
        chk("file_size", e.file_size, out_ch.file_size);
        chk("name0", e.name0, out_ch.out_name0);
        chk("name1", e.name1, out_ch.out_name1);
        chk("name2", e.name2, out_ch.out_name2);
        chk("last", e.last, out_ch.last);
      end
    end
  end

  task automatic test_unformatted_card();
    send_named(FN_CREATE, 0, 3, 0, 0, 0);
    send_named(FN_DELETE, 0, 0, 0, 0, 0);
    send_op(FN_SPAN, 0, 0, 0, 0, 0, 17'd100, 0);
    send_op(FN_LIST, 0, 0, 0, 0, 0, 0, 4'd15);
  endtask

  task automatic test_create_rules();
    send_named(FN_FORMAT, 0, 0, 0, 0, 0);
    send_named(FN_CREATE, 0, 0, 0, 0, 0);
    send_named(FN_CREATE, 0, 3, 0, 0, 0);
    send_named(FN_CREATE, 0, 2, 0, 0, 0);
    send_named(FN_CREATE, 1, 15, 0, 0, 0);
    send_named(FN_CREATE, 4, 1, 0, 0, 0);
    send_named(FN_CREATE, 5, 1, 0, 0, 0);
    send_named(FN_CREATE, 2, 10, 0, 0, 0);
  endtask

  task automatic test_span_and_list();
    send_op(FN_LIST, 0, 0, 0, 0, 0, 0, 4'd15);
    send_op(FN_LIST, 0, 0, 0, 0, 0, 0, 4'd0);
    send_named(FN_SPAN, 0, 0, 0, 0, 0);
    send_named(FN_SPAN, 0, 0, 17'd100, 17'(3 * BBYTES), 0);
    send_named(FN_SPAN, 0, 0, 17'd8191, 17'd2, 0);
    send_named(FN_SPAN, 2, 0, 0, 17'd122880, 0);
    send_named(FN_SPAN, 2, 0, 17'd122879, 17'd1, 0);
    send_named(FN_SPAN, 1, 0, 0, 17'd10, 0);
  endtask

  task automatic test_delete_reuse();
    send_named(FN_DELETE, 0, 0, 0, 0, 0);
    send_named(FN_DELETE, 0, 0, 0, 0, 0);
    send_named(FN_CREATE, 3, 3, 0, 0, 0);
    send_named(FN_UNFORMAT, 0, 0, 0, 0, 0);
    send_named(FN_CREATE, 1, 1, 0, 0, 0);
    send_op(FN_LIST, 0, 0, 0, 0, 0, 0, 4'd2);
    send_op(3'd6, '1, '1, '1, '1, '1, '1, '1);
    send_op(3'd7, '1, '1, '1, '1, '1, '1, '1);
  endtask

  task automatic test_random_ops(int count);
    int sel;
    int p;
    logic [63:0] ra;
    logic [63:0] rb;
    logic [31:0] rc;
    logic [16:0] ln;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(0, 99);
      p = $urandom_range(0, 5);
      ra = {$urandom, $urandom};
      rb = {$urandom, $urandom};
      rc = $urandom;
      ln = ($urandom_range(0, 3) == 0) ? 17'($urandom_range(0, 122880))
                                        : 17'($urandom_range(0, 20000));
      if (i == count / 2) drain_all();
      if (sel < 5) send_named(FN_FORMAT, p, 0, 0, 0, 0);
      else if (sel < 8) begin
        send_named(FN_UNFORMAT, p, 0, 0, 0, 0);
        send_named(FN_FORMAT, p, 0, 0, 0, 0);
      end else if (sel < 38) send_named(FN_CREATE, p, 4'($urandom_range(0, 6)), 0, 0, 0);
      else if (sel < 63)
        send_named(FN_SPAN, p, 0, 17'($urandom_range(0, 122879)), ln, 0);
      else if (sel < 78) send_op(FN_LIST, ra, rb, rc, 0, 0, 0, 4'($urandom_range(0, 15)));
      else if (sel < 93) send_named(FN_DELETE, p, 0, 0, 0, 0);
      else
        send_op(3'($urandom_range(0, 7)), ra, rb, rc, 4'($urandom), 17'($urandom),
                17'($urandom), 4'($urandom));
    end
  endtask

  initial begin
    #10_000_000;
    $display("memory_card_directory_engine_core_tb: done, errors");
    $finish;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.func = '0;
    in_ch.name_part0 = '0;
    in_ch.name_part1 = '0;
    in_ch.name_part2 = '0;
    in_ch.block_count = '0;
    in_ch.byte_offset = '0;
    in_ch.byte_length = '0;
    in_ch.max_entries = '0;
    card_fmt = 1'b0;
    for (int i = 0; i < NBLK; i++) begin
      dir_st[i] = '0;
      dir_link[i] = '0;
      dir_size[i] = '0;
      dir_na[i] = '0;
      dir_nb[i] = '0;
      dir_nc[i] = '0;
    end
    // names that differ only after a zero byte, plus all-ones, all-zero and random
    pool_a[0] = 64'h0000_0000_0041_4141;
    pool_b[0] = '0;
    pool_c[0] = '0;
    pool_a[1] = '1;
    pool_b[1] = '1;
    pool_c[1] = '1;
    pool_a[2] = 64'h0043_0000_0041_4141;
    pool_b[2] = '0;
    pool_c[2] = '0;
    pool_a[3] = {$urandom, $urandom};
    pool_b[3] = {$urandom, $urandom};
    pool_c[3] = $urandom;
    pool_a[4] = '0;
    pool_b[4] = '0;
    pool_c[4] = '0;
    pool_a[5] = 64'h0000_0000_0041_4141;
    pool_b[5] = 64'h8000_0000_0000_0000;
    pool_c[5] = 32'h0000_0001;
    rst_n = 1'b0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    test_unformatted_card();
    stall_mode = 1;
    test_create_rules();
    test_span_and_list();
    test_delete_reuse();
    test_random_ops(150);
    @(negedge clk);
    in_ch.valid = 1'b0;
    drain_all();
    $display("covered %0d operations and %0d result beats across format, create,",
             items_sent, beats_seen);
    $display("delete, span, list and ignored codes with random stalls on both sides");
    if (errors == 0) $display("memory_card_directory_engine_core_tb: done, clean");
    else $display("memory_card_directory_engine_core_tb: done, errors");
    $finish;
  end
endmodule
